[sv/rss_pkg.sv]
// Shared types, constants and trig helpers for the range scan object segmenter.
package rss_pkg;

    localparam int SCAN_STEPS  = 360;
    localparam int MAX_OBJECTS = 10;
    localparam int FIFO_DEPTH  = 4;

    localparam int DIST_W   = 12;
    localparam int ANG_W    = 9;
    localparam int COORD_W  = 13;
    localparam int IDX_W    = 4;
    localparam int SINE_W   = 13;
    localparam int FRAC_W   = 12;
    localparam int PROD_W   = DIST_W + SINE_W;
    localparam int ADDR_W   = $clog2(SCAN_STEPS);
    localparam int CNT_W    = $clog2(MAX_OBJECTS + 1);
    localparam int FIFO_AW  = $clog2(FIFO_DEPTH);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    localparam logic [ANG_W-1:0] QUARTER    = 9'd90;
    localparam logic [ANG_W-1:0] HALF_TURN  = 9'd180;
    localparam logic [ANG_W-1:0] THREE_Q    = 9'd270;
    localparam logic [ANG_W-1:0] FULL_TURN  = 9'd360;
    localparam logic [ANG_W-1:0] LAST_ANGLE = 9'd359;

    // register map, indexed by paddr[2]
    localparam logic REG_THR = 1'b0;
    localparam logic REG_MIN = 1'b1;

    localparam logic [DIST_W-1:0] THR_RESET = 12'd480;
    localparam logic [DIST_W-1:0] MIN_RESET = 12'd32;

    typedef enum logic [1:0] {
        K_NONE,
        K_START,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               first;
        logic [ANG_W-1:0]   angle;
        logic [DIST_W-1:0]  meas;
        logic [ANG_W-1:0]   mid;
        logic [DIST_W-1:0]  mid_dist;
    } t_cmd;

    // first member in the top bits: start_x ends up at bit 0
    typedef struct packed {
        logic [IDX_W-1:0]          object_index;
        logic [DIST_W-1:0]         mid_distance;
        logic [ANG_W-1:0]          mid_angle;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_x;
    } t_obj;

    typedef struct packed {
        logic              neg;
        logic [SINE_W-1:0] mag;
    } t_trig;

    // round(4096*sin(k deg)), k = 0..90
    localparam logic [SINE_W-1:0] QSINE [0:90] = '{
        13'd0,    13'd71,   13'd143,  13'd214,  13'd286,  13'd357,  13'd428,  13'd499,
        13'd570,  13'd641,  13'd711,  13'd782,  13'd852,  13'd921,  13'd991,  13'd1060,
        13'd1129, 13'd1198, 13'd1266, 13'd1334, 13'd1401, 13'd1468, 13'd1534, 13'd1600,
        13'd1666, 13'd1731, 13'd1796, 13'd1860, 13'd1923, 13'd1986, 13'd2048, 13'd2110,
        13'd2171, 13'd2231, 13'd2290, 13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578,
        13'd2633, 13'd2687, 13'd2741, 13'd2793, 13'd2845, 13'd2896, 13'd2946, 13'd2996,
        13'd3044, 13'd3091, 13'd3138, 13'd3183, 13'd3228, 13'd3271, 13'd3314, 13'd3355,
        13'd3396, 13'd3435, 13'd3474, 13'd3511, 13'd3547, 13'd3582, 13'd3617, 13'd3650,
        13'd3681, 13'd3712, 13'd3742, 13'd3770, 13'd3798, 13'd3824, 13'd3849, 13'd3873,
        13'd3896, 13'd3917, 13'd3937, 13'd3956, 13'd3974, 13'd3991, 13'd4006, 13'd4021,
        13'd4034, 13'd4046, 13'd4056, 13'd4065, 13'd4074, 13'd4080, 13'd4086, 13'd4090,
        13'd4094, 13'd4095, 13'd4096
    };

    function automatic logic [ANG_W-1:0] reduce_deg(input logic [ANG_W-1:0] a);
        return (a >= FULL_TURN) ? a - FULL_TURN : a;
    endfunction

    function automatic t_trig sine_deg(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] r;
        t_trig t;
        r = reduce_deg(a);
        t.neg = 1'b0;
        if (r <= QUARTER) begin
            t.mag = QSINE[r[6:0]];
        end else if (r <= HALF_TURN) begin
            t.mag = QSINE[7'(HALF_TURN - r)];
        end else if (r <= THREE_Q) begin
            t.neg = 1'b1;
            t.mag = QSINE[7'(r - HALF_TURN)];
        end else begin
            t.neg = 1'b1;
            t.mag = QSINE[7'(FULL_TURN - r)];
        end
        return t;
    endfunction

    function automatic t_trig cos_deg(input logic [ANG_W-1:0] a);
        return sine_deg(reduce_deg(a) + QUARTER);
    endfunction

endpackage

[sv/rss_front.sv]
// Front end: near/far classification, run tracking and the per-angle distance store.
module rss_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rss_pkg::DIST_W-1:0]  i_dist,
    input  logic [rss_pkg::ANG_W-1:0]   i_angle,
    input  logic                        i_first,
    input  logic [rss_pkg::DIST_W-1:0]  i_thr,
    output logic                        o_push,
    output rss_pkg::t_cmd               o_cmd,
    input  logic                        i_full
);

    logic [rss_pkg::DIST_W-1:0] r_mem [0:rss_pkg::SCAN_STEPS-1];
    logic [rss_pkg::DIST_W-1:0] r_rd;

    logic                        r_prev_near;
    logic [rss_pkg::DIST_W-1:0]  r_prev_sample;
    logic [rss_pkg::ANG_W-1:0]   r_run_angle;

    logic                        r_s1_valid;
    rss_pkg::t_cmd               r_cmd;
    logic                        r_mid_ok;
    logic                        r_byp;
    logic [rss_pkg::DIST_W-1:0]  r_cur_d;

    logic                        w_acc;
    logic                        w_near;
    logic                        w_pn;
    logic                        w_start;
    logic                        w_end;
    logic                        w_in_range;
    logic                        w_mid_ok;
    logic [rss_pkg::ANG_W-1:0]   w_end_angle;
    logic [rss_pkg::ANG_W-1:0]   w_run_eff;
    logic [rss_pkg::ANG_W:0]     w_sum;
    logic [rss_pkg::ANG_W-1:0]   w_mid;
    logic [rss_pkg::ADDR_W-1:0]  w_rd_addr;
    rss_pkg::t_cmd               n_cmd;

    assign o_ready = !r_s1_valid || !i_full;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = r_s1_valid && !i_full;

    assign w_near      = i_dist < i_thr;
    assign w_pn        = i_first ? 1'b0 : r_prev_near;
    assign w_start     = w_near && !w_pn;
    assign w_end       = !w_near && w_pn;
    assign w_end_angle = (i_angle == '0) ? rss_pkg::LAST_ANGLE : i_angle - 1'b1;
    assign w_run_eff   = i_first ? '0 : r_run_angle;
    assign w_sum       = {1'b0, w_run_eff} + {1'b0, w_end_angle};
    assign w_mid       = w_sum[rss_pkg::ANG_W:1];
    assign w_in_range  = int'(i_angle) < rss_pkg::SCAN_STEPS;
    assign w_mid_ok    = int'(w_mid) < rss_pkg::SCAN_STEPS;
    assign w_rd_addr   = w_mid_ok ? rss_pkg::ADDR_W'(w_mid) : '0;

    always_comb begin
        n_cmd.first    = i_first;
        n_cmd.mid      = w_mid;
        n_cmd.mid_dist = '0;
        if (w_start) begin
            n_cmd.kind  = rss_pkg::K_START;
            n_cmd.angle = i_angle;
            n_cmd.meas  = i_dist;
        end else if (w_end) begin
            n_cmd.kind  = rss_pkg::K_END;
            n_cmd.angle = w_end_angle;
            n_cmd.meas  = r_prev_sample;
        end else begin
            n_cmd.kind  = rss_pkg::K_NONE;
            n_cmd.angle = i_angle;
            n_cmd.meas  = i_dist;
        end
    end

    // store is written and read on the same accepted beat; same-address read bypasses
    always_ff @(posedge i_clk) begin
        if (w_acc && w_in_range) begin
            r_mem[rss_pkg::ADDR_W'(i_angle)] <= i_dist;
        end
        if (w_acc) begin
            r_rd     <= r_mem[w_rd_addr];
            r_cmd    <= n_cmd;
            r_mid_ok <= w_mid_ok;
            r_byp    <= w_in_range && (w_mid == i_angle);
            r_cur_d  <= i_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_prev_near   <= 1'b0;
            r_prev_sample <= '0;
            r_run_angle   <= '0;
        end else begin
            if (w_acc) begin
                r_s1_valid    <= 1'b1;
                r_prev_near   <= w_near;
                r_prev_sample <= i_dist;
                if (w_start) begin
                    r_run_angle <= i_angle;
                end else if (i_first) begin
                    r_run_angle <= '0;
                end
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd = r_cmd;
        if (!r_mid_ok) begin
            o_cmd.mid_dist = '0;
        end else if (r_byp) begin
            o_cmd.mid_dist = r_cur_d;
        end else begin
            o_cmd.mid_dist = r_rd;
        end
    end

endmodule

[sv/rss_fifo.sv]
// Short command queue between the front end and the back end.
module rss_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rss_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output rss_pkg::t_cmd  o_head,
    output logic           o_empty
);

    rss_pkg::t_cmd               r_mem [0:rss_pkg::FIFO_DEPTH-1];
    logic [rss_pkg::FIFO_AW-1:0] r_wr;
    logic [rss_pkg::FIFO_AW-1:0] r_rd;
    logic [rss_pkg::FIFO_AW:0]   r_count;

    assign o_full  = int'(r_count) == rss_pkg::FIFO_DEPTH;
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/rss_back.sv]
// Back end: trig lookup, scaling, extent check and the object output register.
module rss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  rss_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    input  logic [rss_pkg::DIST_W-1:0]  i_min_ext,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rss_pkg::t_obj               o_obj
);

    typedef struct packed {
        rss_pkg::t_kind              kind;
        logic                        first;
        logic [rss_pkg::ANG_W-1:0]   mid;
        logic [rss_pkg::DIST_W-1:0]  mid_dist;
    } t_tag;

    logic                             w_en;

    logic                             r1_valid;
    t_tag                             r1_tag;
    logic [rss_pkg::DIST_W-1:0]       r1_dist;
    rss_pkg::t_trig                   r1_sin;
    rss_pkg::t_trig                   r1_cos;

    logic                             r2_valid;
    t_tag                             r2_tag;
    logic                             r2_sneg;
    logic                             r2_cneg;
    logic [rss_pkg::PROD_W-1:0]       r2_ps;
    logic [rss_pkg::PROD_W-1:0]       r2_pc;

    logic                             r3_valid;
    t_tag                             r3_tag;
    logic signed [rss_pkg::COORD_W-1:0] r3_x;
    logic signed [rss_pkg::COORD_W-1:0] r3_y;

    logic                             r_out_valid;
    rss_pkg::t_obj                    r_obj;
    logic [rss_pkg::CNT_W-1:0]        r_count;
    logic signed [rss_pkg::COORD_W-1:0] r_sx;
    logic signed [rss_pkg::COORD_W-1:0] r_sy;

    logic [rss_pkg::PROD_W-1:0]       w_rs;
    logic [rss_pkg::PROD_W-1:0]       w_rc;
    logic [rss_pkg::COORD_W-1:0]      w_qs;
    logic [rss_pkg::COORD_W-1:0]      w_qc;
    logic signed [rss_pkg::COORD_W-1:0] w_x;
    logic signed [rss_pkg::COORD_W-1:0] w_y;

    logic [rss_pkg::CNT_W-1:0]        w_cnt;
    logic signed [rss_pkg::COORD_W-1:0] w_sx;
    logic signed [rss_pkg::COORD_W-1:0] w_sy;
    logic signed [rss_pkg::COORD_W:0] w_dx;
    logic signed [rss_pkg::COORD_W:0] w_dy;
    logic [rss_pkg::COORD_W:0]        w_adx;
    logic [rss_pkg::COORD_W:0]        w_ady;
    logic                             w_emit;
    logic [rss_pkg::CNT_W-1:0]        n_count;
    logic signed [rss_pkg::COORD_W-1:0] n_sx;
    logic signed [rss_pkg::COORD_W-1:0] n_sy;

    assign w_en    = !r_out_valid || i_ready;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_out_valid;
    assign o_obj   = r_obj;

    // round half away from zero on the magnitude, then apply the sign
    assign w_rs = (r2_ps + rss_pkg::ROUND_HALF) >> rss_pkg::FRAC_W;
    assign w_rc = (r2_pc + rss_pkg::ROUND_HALF) >> rss_pkg::FRAC_W;
    assign w_qs = rss_pkg::COORD_W'(w_rs);
    assign w_qc = rss_pkg::COORD_W'(w_rc);
    assign w_x  = r2_sneg ? $signed(w_qs) : -$signed(w_qs);
    assign w_y  = r2_cneg ? -$signed(w_qc) : $signed(w_qc);

    assign w_cnt  = r3_tag.first ? '0 : r_count;
    assign w_sx   = r3_tag.first ? '0 : r_sx;
    assign w_sy   = r3_tag.first ? '0 : r_sy;
    assign w_dx   = {r3_x[rss_pkg::COORD_W-1], r3_x} - {w_sx[rss_pkg::COORD_W-1], w_sx};
    assign w_dy   = {r3_y[rss_pkg::COORD_W-1], r3_y} - {w_sy[rss_pkg::COORD_W-1], w_sy};
    assign w_adx  = w_dx[rss_pkg::COORD_W] ? $unsigned(-w_dx) : $unsigned(w_dx);
    assign w_ady  = w_dy[rss_pkg::COORD_W] ? $unsigned(-w_dy) : $unsigned(w_dy);
    assign w_emit = (r3_tag.kind == rss_pkg::K_END)
                  && (int'(w_cnt) < rss_pkg::MAX_OBJECTS)
                  && (w_adx >= (rss_pkg::COORD_W + 1)'(i_min_ext))
                  && (w_ady >= (rss_pkg::COORD_W + 1)'(i_min_ext));

    assign n_count = w_emit ? w_cnt + 1'b1 : w_cnt;
    assign n_sx    = (r3_tag.kind == rss_pkg::K_START) ? r3_x : w_sx;
    assign n_sy    = (r3_tag.kind == rss_pkg::K_START) ? r3_y : w_sy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tag  <= '{kind: i_cmd.kind, first: i_cmd.first, mid: i_cmd.mid,
                         mid_dist: i_cmd.mid_dist};
            r1_dist <= i_cmd.meas;
            r1_sin  <= rss_pkg::sine_deg(i_cmd.angle);
            r1_cos  <= rss_pkg::cos_deg(i_cmd.angle);

            r2_tag  <= r1_tag;
            r2_sneg <= r1_sin.neg;
            r2_cneg <= r1_cos.neg;
            r2_ps   <= rss_pkg::PROD_W'(r1_dist) * rss_pkg::PROD_W'(r1_sin.mag);
            r2_pc   <= rss_pkg::PROD_W'(r1_dist) * rss_pkg::PROD_W'(r1_cos.mag);

            r3_tag  <= r2_tag;
            r3_x    <= w_x;
            r3_y    <= w_y;

            if (r3_valid && w_emit) begin
                r_obj.start_x      <= w_sx;
                r_obj.start_y      <= w_sy;
                r_obj.end_x        <= r3_x;
                r_obj.end_y        <= r3_y;
                r_obj.mid_angle    <= r3_tag.mid;
                r_obj.mid_distance <= r3_tag.mid_dist;
                r_obj.object_index <= rss_pkg::IDX_W'(w_cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
        end else if (w_en) begin
            r1_valid    <= o_pop;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid && w_emit;
            if (r3_valid) begin
                r_count <= n_count;
                r_sx    <= n_sx;
                r_sy    <= n_sy;
            end
        end
    end

endmodule

[sv/range_scan_object_segmenter.sv]
// Top level of the range scan object segmenter: stream ports, APB registers, front/queue/back.
// A beat passes the front register, the queue, the back-end stages and the output register.
// Throughput: one input beat per cycle while the queue is not full; a four-entry queue decouples front and back.
// The back end advances whenever its output register is empty or being taken.
// Reset is synchronous, active low: run state, object count, queue and valids clear,
// registers return to 480 and 32; the distance store is not cleared.
module range_scan_object_segmenter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rss_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // distance[11:0], angle[20:12], zero pad
    input  logic                            i_s_tuser,   // sweep_start
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // start_x[12:0], start_y[25:13], end_x[38:26], end_y[51:39], mid_angle[60:52],
    // mid_distance[72:61], object_index[76:73], zero pad
    output logic [rss_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rss_pkg::PADDR_W-1:0]     paddr,
    input  logic [rss_pkg::PDATA_W-1:0]     pwdata,
    output logic [rss_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic [rss_pkg::DIST_W-1:0] r_thr;
    logic [rss_pkg::DIST_W-1:0] r_min_ext;
    logic                       w_wr;

    logic                       w_push;
    logic                       w_full;
    logic                       w_pop;
    logic                       w_empty;
    rss_pkg::t_cmd              w_cmd_in;
    rss_pkg::t_cmd              w_cmd_head;
    rss_pkg::t_obj              w_obj;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= rss_pkg::THR_RESET;
            r_min_ext <= rss_pkg::MIN_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                rss_pkg::REG_THR: r_thr     <= pwdata[rss_pkg::DIST_W-1:0];
                rss_pkg::REG_MIN: r_min_ext <= pwdata[rss_pkg::DIST_W-1:0];
                default:          r_thr     <= r_thr;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rss_pkg::REG_THR: prdata = rss_pkg::PDATA_W'(r_thr);
            rss_pkg::REG_MIN: prdata = rss_pkg::PDATA_W'(r_min_ext);
            default:          prdata = '0;
        endcase
    end

    rss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_dist  (i_s_tdata[rss_pkg::DIST_W-1:0]),
        .i_angle (i_s_tdata[rss_pkg::DIST_W +: rss_pkg::ANG_W]),
        .i_first (i_s_tuser),
        .i_thr   (r_thr),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in),
        .i_full  (w_full)
    );

    rss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_cmd_head),
        .o_empty (w_empty)
    );

    rss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_cmd     (w_cmd_head),
        .o_pop     (w_pop),
        .i_min_ext (r_min_ext),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_obj     (w_obj)
    );

    assign o_m_tdata = rss_pkg::OUT_TDATA_W'(w_obj);

endmodule

[sv/rss_checker.sv]
// Port-level checks for the range scan object segmenter, bound to the top level.
module rss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rss_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                            psel,
    input logic                            pwrite,
    input logic [rss_pkg::PDATA_W-1:0]     prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat dropped or changed while stalled");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> int'(o_m_tdata[76:73]) < rss_pkg::MAX_OBJECTS)
        else $error("object index beyond object limit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not idle after reset");

    a_reg_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite |-> prdata[31:12] == 20'd0)
        else $error("register read returns bits above 12");

endmodule

bind range_scan_object_segmenter rss_checker u_rss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .psel       (psel),
    .pwrite     (pwrite),
    .prdata     (prdata)
);

[verif/tb_top.sv]
// Testbench for the range scan object segmenter: stream stimulus, APB setup, predicted objects.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_SETTINGS   = 6;

    localparam logic [rss_pkg::PADDR_W-1:0] ADDR_NEAR_THR   = 3'd0;
    localparam logic [rss_pkg::PADDR_W-1:0] ADDR_MIN_EXTENT = 3'd4;

    localparam logic [11:0] THR_AT_RESET = 12'd480;
    localparam logic [11:0] MIN_AT_RESET = 12'd32;
    localparam logic [8:0]  LAST_DEG     = 9'd359;

    // round(4096*sin(k deg)), k = 0..90
    localparam int QUARTER_SINE [91] = '{
        0, 71, 143, 214, 286, 357, 428, 499, 570, 641,
        711, 782, 852, 921, 991, 1060, 1129, 1198, 1266, 1334,
        1401, 1468, 1534, 1600, 1666, 1731, 1796, 1860, 1923, 1986,
        2048, 2110, 2171, 2231, 2290, 2349, 2408, 2465, 2522, 2578,
        2633, 2687, 2741, 2793, 2845, 2896, 2946, 2996, 3044, 3091,
        3138, 3183, 3228, 3271, 3314, 3355, 3396, 3435, 3474, 3511,
        3547, 3582, 3617, 3650, 3681, 3712, 3742, 3770, 3798, 3824,
        3849, 3873, 3896, 3917, 3937, 3956, 3974, 3991, 4006, 4021,
        4034, 4046, 4056, 4065, 4074, 4080, 4086, 4090, 4094, 4095,
        4096
    };

    localparam int THR_SET  [N_SETTINGS] = '{480, 4095, 1200, 2500, 1, 800};
    localparam int MIN_SET  [N_SETTINGS] = '{32, 0, 200, 4095, 0, 64};
    localparam int SRC_IDLE [N_SETTINGS] = '{30, 0, 50, 20, 40, 10};
    localparam int SNK_IDLE [N_SETTINGS] = '{30, 0, 60, 20, 50, 15};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [rss_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;   // distance[11:0], angle[20:12], pad
    logic                            i_s_tuser  = 1'b0; // sweep_start
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // start_x, start_y, end_x, end_y, mid_angle, mid_distance, object_index, pad
    logic [rss_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [rss_pkg::PADDR_W-1:0]     paddr   = '0;
    logic [rss_pkg::PDATA_W-1:0]     pwdata  = '0;
    logic [rss_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;

    // segmenter shadow state
    logic [11:0]        near_thr  = THR_AT_RESET;
    logic [11:0]        min_ext   = MIN_AT_RESET;
    logic               prev_near = 1'b0;
    logic [8:0]         run_ang   = '0;
    logic signed [12:0] run_x     = '0;
    logic signed [12:0] run_y     = '0;
    logic [11:0]        prev_dist = '0;
    logic [3:0]         obj_count = '0;
    logic [11:0]        range_mem  [rss_pkg::SCAN_STEPS];
    logic               range_seen [rss_pkg::SCAN_STEPS] = '{default: 1'b0};

    rss_pkg::t_obj pending_objects [$];

    int error_count    = 0;
    int samples_sent   = 0;
    int objects_seen   = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 20;
    int sink_stall_pct = 20;
    int stall_left     = 0;

    range_scan_object_segmenter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int idle_len(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            stall_left <= idle_len(sink_stall_pct);
        end
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic int sin_q12(input int deg);
        int r;
        r = deg % 360;
        if (r <= 90) return QUARTER_SINE[r];
        if (r <= 180) return QUARTER_SINE[180 - r];
        if (r <= 270) return -QUARTER_SINE[r - 180];
        return -QUARTER_SINE[360 - r];
    endfunction

    // d * s in Q1.12, rounded half away from zero, back to Q8.4
    function automatic int q84_scale(input logic [11:0] meas, input int s);
        int p;
        p = int'(meas) * s;
        if (p >= 0) return (p + 2048) >>> 12;
        return -((-p + 2048) >>> 12);
    endfunction

    function automatic void polar_xy(input logic [11:0] meas, input logic [8:0] ang,
                                     output logic signed [12:0] x,
                                     output logic signed [12:0] y);
        x = 13'(-q84_scale(meas, sin_q12(int'(ang))));
        y = 13'(q84_scale(meas, sin_q12(int'(ang) % 360 + 90)));
    endfunction

    function automatic logic [8:0] mid_of(input logic [8:0] a0, input logic [8:0] a1);
        return 9'((int'(a0) + int'(a1)) >> 1);
    endfunction

    // true when closing the open run here would look up a never-written store entry
    function automatic logic would_read_unwritten(input logic [11:0] meas,
                                                  input logic [8:0] ang, input logic first);
        logic [8:0] end_ang;
        logic [8:0] mid;
        if (first || !prev_near || meas < near_thr) return 1'b0;
        end_ang = (ang == 9'd0) ? LAST_DEG : ang - 9'd1;
        mid = mid_of(run_ang, end_ang);
        return (mid < rss_pkg::SCAN_STEPS) && (mid != ang) && !range_seen[mid];
    endfunction

    function automatic void segment_sample(input logic [11:0] meas, input logic [8:0] ang,
                                           input logic first);
        logic               near;
        logic [8:0]         end_ang;
        logic [8:0]         mid;
        logic signed [12:0] ex;
        logic signed [12:0] ey;
        int                 dx;
        int                 dy;
        rss_pkg::t_obj      obj;
        if (first) begin
            prev_near = 1'b0;
            run_ang   = '0;
            run_x     = '0;
            run_y     = '0;
            obj_count = '0;
        end
        if (ang < rss_pkg::SCAN_STEPS) begin
            range_mem[ang]  = meas;
            range_seen[ang] = 1'b1;
        end
        near = meas < near_thr;
        if (near && !prev_near) begin
            run_ang = ang;
            polar_xy(meas, ang, run_x, run_y);
        end else if (!near && prev_near) begin
            end_ang = (ang == 9'd0) ? LAST_DEG : ang - 9'd1;
            polar_xy(prev_dist, end_ang, ex, ey);
            dx = int'(ex) - int'(run_x);
            dy = int'(ey) - int'(run_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (obj_count < rss_pkg::MAX_OBJECTS && dx >= int'(min_ext)
                    && dy >= int'(min_ext)) begin
                mid = mid_of(run_ang, end_ang);
                obj.start_x      = run_x;
                obj.start_y      = run_y;
                obj.end_x        = ex;
                obj.end_y        = ey;
                obj.mid_angle    = mid;
                obj.mid_distance = (mid < rss_pkg::SCAN_STEPS) ? range_mem[mid] : 12'd0;
                obj.object_index = obj_count;
                pending_objects.push_back(obj);
                obj_count++;
            end
        end
        prev_near = near;
        prev_dist = meas;
    endfunction

    function automatic void check_object(input logic [rss_pkg::OUT_TDATA_W-1:0] beat);
        rss_pkg::t_obj got;
        rss_pkg::t_obj want;
        string         bad;
        got = beat[$bits(rss_pkg::t_obj)-1:0];
        objects_seen++;
        if (pending_objects.size() == 0) begin
            note_error($sformatf("object beat with nothing expected: %h", beat));
            return;
        end
        want = pending_objects.pop_front();
        bad = "";
        if (got.start_x !== want.start_x) bad = {bad, " start_x"};
        if (got.start_y !== want.start_y) bad = {bad, " start_y"};
        if (got.end_x !== want.end_x) bad = {bad, " end_x"};
        if (got.end_y !== want.end_y) bad = {bad, " end_y"};
        if (got.mid_angle !== want.mid_angle) bad = {bad, " mid_angle"};
        if (got.mid_distance !== want.mid_distance) bad = {bad, " mid_distance"};
        if (got.object_index !== want.object_index) bad = {bad, " object_index"};
        if (bad != "")
            note_error({
                $sformatf("object mismatch on%s: exp %0d,%0d %0d,%0d ang %0d dist %0d idx %0d",
                          bad, want.start_x, want.start_y, want.end_x, want.end_y,
                          want.mid_angle, want.mid_distance, want.object_index),
                $sformatf(" / got %0d,%0d %0d,%0d ang %0d dist %0d idx %0d",
                          got.start_x, got.start_y, got.end_x, got.end_y,
                          got.mid_angle, got.mid_distance, got.object_index)});
    endfunction

    // sampled mid-cycle: a beat seen here is taken at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) check_object(o_m_tdata);
    end

    task automatic send_sample(input logic [11:0] meas, input logic [8:0] ang,
                               input logic first);
        int gap;
        gap = idle_len(src_idle_pct);
        if (would_read_unwritten(meas, ang, first)) first = 1'b1;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, ang, meas};
        i_s_tuser  <= first;
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        segment_sample(meas, ang, first);
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_objects.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rss_pkg::PADDR_W-1:0] addr,
                             input logic [rss_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_reg(input logic [rss_pkg::PADDR_W-1:0] addr,
                              input logic [11:0] value);
        logic [rss_pkg::PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        rd = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== 32'(value))
            note_error($sformatf("register at %0d: exp %0d got %0d", addr, value, rd));
    endtask

    task automatic apply_config(input logic [11:0] thr, input logic [11:0] min_e);
        wait_idle();
        write_reg(ADDR_NEAR_THR, 32'(thr));
        near_thr = thr;
        write_reg(ADDR_MIN_EXTENT, 32'(min_e));
        min_ext = min_e;
        verify_reg(ADDR_NEAR_THR, thr);
        verify_reg(ADDR_MIN_EXTENT, min_e);
    endtask

    function automatic logic [11:0] far_sample();
        return 12'($urandom_range(int'(near_thr), 4095));
    endfunction

    function automatic logic [11:0] near_sample(input int base);
        int v;
        if (near_thr == 12'd0) return far_sample();
        if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, int'(near_thr) - 1));
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v >= int'(near_thr)) v = int'(near_thr) - 1;
        return 12'(v);
    endfunction

    // one sweep of alternating near and far stretches at consecutive angles
    task automatic send_sweep(input int len);
        logic [8:0]  ang;
        logic [11:0] meas;
        logic        near_run;
        int          left_in_run;
        int          base;
        ang = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom_range(0, 359));
        near_run = 1'($urandom_range(0, 1));
        left_in_run = 0;
        base = 0;
        for (int k = 0; k < len; k++) begin
            if (left_in_run == 0) begin
                near_run = !near_run;
                left_in_run = near_run ? $urandom_range(1, 40) : $urandom_range(1, 25);
                base = (near_thr == 12'd0) ? 0 : $urandom_range(0, int'(near_thr) - 1);
            end
            meas = near_run ? near_sample(base) : far_sample();
            send_sample(meas, ang, k == 0);
            ang = (ang == LAST_DEG) ? 9'd0 : ang + 9'd1;
            left_in_run--;
        end
    endtask

    task automatic test_register_reset();
        verify_reg(ADDR_NEAR_THR, THR_AT_RESET);
        verify_reg(ADDR_MIN_EXTENT, MIN_AT_RESET);
    endtask

    task automatic test_sweep_cases();
        send_sample(12'd4095, 9'd350, 1'b1);
        send_sample(12'd479, 9'd351, 1'b0);
        send_sample(12'd0, 9'd352, 1'b0);
        send_sample(12'd300, 9'd353, 1'b0);
        for (int a = 354; a < 359; a++) send_sample(12'd200, 9'(a), 1'b0);
        send_sample(12'd100, 9'd359, 1'b0);
        send_sample(12'd480, 9'd0, 1'b0);     // run ends on the wrap to zero
        send_sample(12'd10, 9'd1, 1'b0);
        send_sample(12'd12, 9'd2, 1'b0);
        send_sample(12'd4095, 9'd3, 1'b0);    // too small, dropped
        send_sample(12'd4095, 9'd358, 1'b1);
        send_sample(12'd50, 9'd359, 1'b0);
        send_sample(12'd50, 9'd360, 1'b0);
        send_sample(12'd400, 9'd450, 1'b0);
        send_sample(12'd4095, 9'd511, 1'b0);  // middle angle lies past the store
        send_sample(12'd100, 9'd100, 1'b0);
        send_sample(12'd100, 9'd50, 1'b1);    // open run dropped by new sweep
        send_sample(12'd4095, 9'd51, 1'b0);
    endtask

    task automatic test_object_limit();
        apply_config(12'd4095, 12'd0);
        for (int k = 0; k < 12; k++) begin
            send_sample(12'($urandom_range(0, 4094)), 9'(2 * k + 10), k == 0);
            send_sample(12'd4095, 9'(2 * k + 11), 1'b0);
        end
        send_sample(12'd4094, 9'd100, 1'b1);
        send_sample(12'd4095, 9'd101, 1'b0);
        apply_config(12'd0, 12'd4095);
        send_sample(12'd0, 9'd200, 1'b1);
        send_sample(12'd0, 9'd201, 1'b0);
        send_sample(12'd4095, 9'd202, 1'b0);
    endtask

    task automatic test_random_sweeps();
        int budget;
        int n;
        for (int s = 0; s < N_SETTINGS; s++) begin
            apply_config(12'(THR_SET[s]), 12'(MIN_SET[s]));
            src_idle_pct   = SRC_IDLE[s];
            sink_stall_pct = SNK_IDLE[s];
            budget = 200;
            while (budget > 0) begin
                if ($urandom_range(0, 99) < 15) begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_sample(12'($urandom_range(0, 4095)), 9'($urandom_range(0, 511)),
                                    $urandom_range(0, 7) == 0);
                end else begin
                    n = ($urandom_range(0, 3) == 0) ? 360 : $urandom_range(16, 120);
                    send_sweep(n);
                end
                budget -= n;
            end
        end
        apply_config(THR_AT_RESET, MIN_AT_RESET);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_sweep_cases();
        test_object_limit();
        test_random_sweeps();
        wait_idle();
        $display("Sent %0d range samples over %0d threshold settings; %0d objects checked.",
                 samples_sent, N_SETTINGS + 3, objects_seen);
        $display("Mismatches counted: %0d", error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
sv/rss_pkg.sv
sv/rss_front.sv
sv/rss_fifo.sv
sv/rss_back.sv
sv/range_scan_object_segmenter.sv
sv/rss_checker.sv
verif/tb_top.sv
